[sv/rrqbp_pkg.sv]
// rrqbp_pkg: types, field widths and operation codes for the record ring queue
// used by rrqbp_ctrl, rrqbp_dp and record_ring_queue_batch_peek; no dependencies
package rrqbp_pkg;

	// default configuration
	localparam int CAPACITY_DEF  = 64;
	localparam int UID_BYTES_DEF = 7;

	// fixed field widths
	localparam int KIND_W    = 2;
	localparam int INLEN_W   = 4;
	localparam int UIDB_W    = 56;
	localparam int TIME_W    = 32;
	localparam int CNT_W     = 6;
	localparam int SLOT_W    = 6;
	localparam int LEN_W     = 3;
	localparam int OCC_W     = 6;
	localparam int UID_SLOTS = UIDB_W / 8;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COMMIT = 2'd2;

	// input item
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [INLEN_W-1:0] in_uid_len;
		logic [UIDB_W-1:0]  in_uid_bytes;
		logic [TIME_W-1:0]  in_time;
		logic               in_sms_sent;
		logic [CNT_W-1:0]   count;
	} req_t;

	// result item
	typedef struct packed {
		logic               push_accepted;
		logic               record_valid;
		logic [SLOT_W-1:0]  out_slot;
		logic [LEN_W-1:0]   out_uid_len;
		logic [UIDB_W-1:0]  out_uid_bytes;
		logic [TIME_W-1:0]  out_time;
		logic               out_sms_sent;
		logic [OCC_W-1:0]   occupancy;
		logic               last;
	} rsp_t;

	// one stored record
	typedef struct packed {
		logic [LEN_W-1:0]  uid_len;
		logic [UIDB_W-1:0] uid_bytes;
		logic [TIME_W-1:0] stamp;
		logic              sent;
	} rec_t;

	// controller to datapath
	typedef struct packed {
		logic take;   // input transfer this cycle
		logic rd;     // read record at peek pointer
		logic emit;   // load read record into result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;  // result register can load this cycle
		logic peek_go;   // presented item is a peek with records to emit
		logic last;      // current peeked record is the final one
	} sts_t;

endpackage

[sv/rrqbp_ctrl.sv]
// rrqbp_ctrl: sequencer for the record ring queue (accept, read, emit)
// depends on rrqbp_pkg
module rrqbp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  rrqbp_pkg::sts_t sts,
	output rrqbp_pkg::cmd_t cmd
);
	import rrqbp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RD   = 3'b010,
		ST_LD   = 3'b100
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = !sts.out_free;
				if (req_valid && sts.out_free) begin
					cmd.take = 1'b1;
					if (sts.peek_go) begin
						state_d = ST_RD;
					end
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_LD;
			end
			ST_LD: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.last ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/rrqbp_dp.sv]
// rrqbp_dp: ring pointers, occupancy, record memory and result register
// depends on rrqbp_pkg
module rrqbp_dp #(
	parameter int CAPACITY  = rrqbp_pkg::CAPACITY_DEF,
	parameter int UID_BYTES = rrqbp_pkg::UID_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rrqbp_pkg::req_t req,
	input  logic            rsp_stall,
	output logic            rsp_valid,
	output rrqbp_pkg::rsp_t rsp,
	input  rrqbp_pkg::cmd_t cmd,
	output rrqbp_pkg::sts_t sts
);
	import rrqbp_pkg::*;

	localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [PW-1:0]    head_q, tail_q, rd_ptr_q;
	logic [OCC_W-1:0] occ_q, rem_q;
	logic             out_valid_q;
	rsp_t             rsp_q;
	rec_t             rd_data_q;
	rec_t             mem_q [CAPACITY];

	logic             full, push_ok, is_push, is_peek, is_commit;
	logic [OCC_W-1:0] n_clamp;
	logic [INLEN_W-1:0] len_c;
	rec_t             wr_rec;
	rsp_t             op_rsp, rec_rsp;

	// wrapping add of a count below the capacity
	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [PW-1:0] n);
		logic [PW:0] s;
		s = {1'b0, p} + {1'b0, n};
		if (s >= (PW+1)'(CAPACITY)) begin
			s = s - (PW+1)'(CAPACITY);
		end
		return s[PW-1:0];
	endfunction

	// decode of the presented item
	assign is_push   = (req.kind == KIND_PUSH);
	assign is_peek   = (req.kind == KIND_PEEK);
	assign is_commit = (req.kind == KIND_COMMIT);
	assign full      = (occ_q == OCC_W'(CAPACITY - 1));
	assign push_ok   = is_push && !full;
	assign n_clamp   = (occ_q < req.count) ? occ_q : req.count;

	// clamp length and zero bytes past it
	always_comb begin
		len_c = (req.in_uid_len > INLEN_W'(UID_BYTES)) ? INLEN_W'(UID_BYTES) : req.in_uid_len;
		wr_rec.uid_len = len_c[LEN_W-1:0];
		wr_rec.stamp   = req.in_time;
		wr_rec.sent    = req.in_sms_sent;
		for (int b = 0; b < UID_SLOTS; b++) begin
			wr_rec.uid_bytes[b*8 +: 8] = (INLEN_W'(b) < len_c) ? req.in_uid_bytes[b*8 +: 8] : 8'd0;
		end
	end

	// single result for push, commit, empty peek and unused codes
	always_comb begin
		op_rsp      = '0;
		op_rsp.last = 1'b1;
		case (req.kind)
			KIND_PUSH: begin
				op_rsp.push_accepted = push_ok;
				op_rsp.occupancy     = occ_q + OCC_W'(push_ok);
			end
			KIND_COMMIT: begin
				op_rsp.occupancy = occ_q - n_clamp;
			end
			default: begin
				op_rsp.occupancy = occ_q;
			end
		endcase
	end

	// result for one peeked record
	always_comb begin
		rec_rsp               = '0;
		rec_rsp.record_valid  = 1'b1;
		rec_rsp.out_slot      = SLOT_W'(rd_ptr_q);
		rec_rsp.out_uid_len   = rd_data_q.uid_len;
		rec_rsp.out_uid_bytes = rd_data_q.uid_bytes;
		rec_rsp.out_time      = rd_data_q.stamp;
		rec_rsp.out_sms_sent  = rd_data_q.sent;
		rec_rsp.occupancy     = occ_q;
		rec_rsp.last          = (rem_q == OCC_W'(1));
	end

	// status to controller
	assign sts.out_free = !out_valid_q || !rsp_stall;
	assign sts.peek_go  = is_peek && (n_clamp != '0);
	assign sts.last     = (rem_q == OCC_W'(1));

	// pointers, counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			rem_q       <= '0;
			rd_ptr_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				if (push_ok) begin
					tail_q <= wrap_add(tail_q, PW'(1));
					occ_q  <= occ_q + OCC_W'(1);
				end
				if (is_commit) begin
					head_q <= wrap_add(head_q, n_clamp[PW-1:0]);
					occ_q  <= occ_q - n_clamp;
				end
				if (sts.peek_go) begin
					rem_q    <= n_clamp;
					rd_ptr_q <= head_q;
				end
			end
			if (cmd.emit) begin
				rem_q    <= rem_q - OCC_W'(1);
				rd_ptr_q <= wrap_add(rd_ptr_q, PW'(1));
			end
			if ((cmd.take && !sts.peek_go) || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// record memory, registered read and result register
	always_ff @(posedge clk) begin
		if (cmd.take && push_ok) begin
			mem_q[tail_q] <= wr_rec;
		end
		if (cmd.rd) begin
			rd_data_q <= mem_q[rd_ptr_q];
		end
		if (cmd.take && !sts.peek_go) begin
			rsp_q <= op_rsp;
		end else if (cmd.emit) begin
			rsp_q <= rec_rsp;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

endmodule

[sv/record_ring_queue_batch_peek.sv]
// record_ring_queue_batch_peek: ring queue of tap records with batch peek and commit
// depends on rrqbp_pkg, rrqbp_ctrl, rrqbp_dp
//
//  channel | valid     | stall     | payload
//  input   | req_valid | req_stall | req (rrqbp_pkg::req_t)
//  result  | rsp_valid | rsp_stall | rsp (rrqbp_pkg::rsp_t)
//
// push, commit, empty peek and unused codes: result registered at the accepting
// edge and offered from the next cycle; a new item is taken while the result
// register drains. a peek of n records then runs, per record, a registered memory
// read and then a load of the result register.
// reset clears pointers, occupancy and the sequencer; the memory holds no reset.
// a stalled result holds the sequencer in its load step and stalls the input.
module record_ring_queue_batch_peek #(
	parameter int CAPACITY  = rrqbp_pkg::CAPACITY_DEF,
	parameter int UID_BYTES = rrqbp_pkg::UID_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  rrqbp_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output rrqbp_pkg::rsp_t rsp
);
	import rrqbp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	rrqbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// queue storage and result register
	rrqbp_dp #(
		.CAPACITY  (CAPACITY),
		.UID_BYTES (UID_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

[tb/ring_queue_checker.sv]
// ring_queue_checker: watches both channels of record_ring_queue_batch_peek,
// keeps its own copy of the record ring and compares every result in order
// depends on rrqbp_pkg
module ring_queue_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_stall,
	input  rrqbp_pkg::req_t req,
	input  logic            rsp_valid,
	input  logic            rsp_stall,
	input  rrqbp_pkg::rsp_t rsp,
	output int              errors,
	output int              awaited,
	output int              requests,
	output int              results,
	output int              refused,
	output int              peeked,
	output int              peak_held
);
	timeunit 1ns;
	timeprecision 1ps;
	import rrqbp_pkg::*;

	// predicted ring: pointers start cleared, slots are only read once written
	logic [SLOT_W-1:0] rd_ptr = '0;
	logic [SLOT_W-1:0] wr_ptr = '0;
	rec_t              ring [CAPACITY_DEF];
	rsp_t              awaited_rsp [$];

	initial begin
		errors    = 0;
		awaited   = 0;
		requests  = 0;
		results   = 0;
		refused   = 0;
		peeked    = 0;
		peak_held = 0;
	end

	// records held, one slot always left empty
	function automatic logic [OCC_W-1:0] ring_fill();
		return OCC_W'(wr_ptr - rd_ptr);
	endfunction

	// apply one operation to the ring and queue the results it should give
	function automatic void predict_ring_op(input req_t item);
		rsp_t              r;
		logic [SLOT_W-1:0] nxt;
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0]  len;
		logic [UIDB_W-1:0] keep;
		logic [OCC_W-1:0]  n;
		int                i;
		bit                batch;
		r      = '0;
		r.last = 1'b1;
		batch  = 1'b0;
		case (item.kind)
			KIND_PUSH: begin
				nxt = wr_ptr + SLOT_W'(1);
				if (nxt != rd_ptr) begin
					len  = (item.in_uid_len > UID_BYTES_DEF) ? LEN_W'(UID_BYTES_DEF)
						: item.in_uid_len[LEN_W-1:0];
					// bytes past the stored length read back as zero
					keep = (UIDB_W'(1) << (8 * len)) - UIDB_W'(1);
					ring[wr_ptr] = '{uid_len: len, uid_bytes: item.in_uid_bytes & keep,
						stamp: item.in_time, sent: item.in_sms_sent};
					wr_ptr          = nxt;
					r.push_accepted = 1'b1;
				end else begin
					refused++;
				end
			end
			KIND_PEEK: begin
				n = (item.count < ring_fill()) ? item.count : ring_fill();
				// one result per record from the head, nothing removed
				for (i = 0; i < n; i++) begin
					slot            = rd_ptr + SLOT_W'(i);
					r.record_valid  = 1'b1;
					r.out_slot      = slot;
					r.out_uid_len   = ring[slot].uid_len;
					r.out_uid_bytes = ring[slot].uid_bytes;
					r.out_time      = ring[slot].stamp;
					r.out_sms_sent  = ring[slot].sent;
					r.occupancy     = ring_fill();
					r.last          = (i == n - 1);
					awaited_rsp.push_back(r);
				end
				peeked += int'(n);
				batch   = (n != 0);
			end
			KIND_COMMIT: begin
				n      = (item.count < ring_fill()) ? item.count : ring_fill();
				rd_ptr = rd_ptr + n;
			end
			default: begin
			end
		endcase
		// push, commit, empty peek and the unused code give a single result
		if (!batch) begin
			r.occupancy = ring_fill();
			awaited_rsp.push_back(r);
		end
		if (int'(ring_fill()) > peak_held)
			peak_held = int'(ring_fill());
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
			errors++;
		end
	endtask

	// sample both channels at the edge, results before new requests
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			// result transfer: compare with the oldest awaited result
			if (rsp_valid && !rsp_stall) begin
				results++;
				if (awaited_rsp.size() == 0) begin
					$error("result with nothing awaited: 'h%0h", rsp);
					errors++;
				end else begin
					want = awaited_rsp.pop_front();
					check_field("push_accepted", 64'(want.push_accepted),
						64'(rsp.push_accepted));
					check_field("record_valid", 64'(want.record_valid),
						64'(rsp.record_valid));
					check_field("out_slot", 64'(want.out_slot), 64'(rsp.out_slot));
					check_field("out_uid_len", 64'(want.out_uid_len), 64'(rsp.out_uid_len));
					check_field("out_uid_bytes", 64'(want.out_uid_bytes),
						64'(rsp.out_uid_bytes));
					check_field("out_time", 64'(want.out_time), 64'(rsp.out_time));
					check_field("out_sms_sent", 64'(want.out_sms_sent),
						64'(rsp.out_sms_sent));
					check_field("occupancy", 64'(want.occupancy), 64'(rsp.occupancy));
					check_field("last", 64'(want.last), 64'(rsp.last));
				end
			end
			// request transfer: extend the awaited results
			if (req_valid && !req_stall) begin
				requests++;
				predict_ring_op(req);
			end
			awaited = awaited_rsp.size();
		end
	end

endmodule

[tb/testbench.sv]
// testbench: drives pushes, batch peeks and commits into record_ring_queue_batch_peek
// with random gaps and stalls; checking is done by ring_queue_checker
// depends on rrqbp_pkg, record_ring_queue_batch_peek, ring_queue_checker
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rrqbp_pkg::*;

	// code the block leaves unused
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	localparam int FILL_ITEMS      = 66;
	localparam int MIXED_ITEMS     = 70;
	localparam int HOLD_OFF_AT     = 40;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 30;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	bit   tx_calm   = 1'b0;

	int errors, awaited, requests, results, refused, peeked, peak_held;

	record_ring_queue_batch_peek u_top (
		.clk, .arst_n, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp
	);

	ring_queue_checker u_check (
		.clk, .arst_n, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
		.errors, .awaited, .requests, .results, .refused, .peeked, .peak_held
	);

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// run limit
	initial begin
		#12_000_000;
		$display("testbench: errors");
		$finish;
	end

	// request with random payload around a given operation and count
	function automatic req_t rand_req(input logic [KIND_W-1:0] kind,
			input logic [CNT_W-1:0] cnt);
		req_t item;
		item.kind         = kind;
		item.in_uid_len   = INLEN_W'($urandom_range(0, 15));
		item.in_uid_bytes = UIDB_W'({$urandom, $urandom});
		item.in_time      = $urandom;
		item.in_sms_sent  = 1'($urandom_range(0, 1));
		item.count        = cnt;
		return item;
	endfunction

	// one request transfer after a random gap; valid stays high into a gapless next item
	task automatic send(input req_t item);
		int gap;
		if ($urandom_range(0, 11) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic op(input logic [KIND_W-1:0] kind, input logic [CNT_W-1:0] cnt);
		send(rand_req(kind, cnt));
	endtask

	task automatic push_rec(input logic [INLEN_W-1:0] len, input logic [UIDB_W-1:0] bytes,
			input logic [TIME_W-1:0] stamp, input logic sent);
		req_t item;
		item              = rand_req(KIND_PUSH, CNT_W'($urandom_range(0, 63)));
		item.in_uid_len   = len;
		item.in_uid_bytes = bytes;
		item.in_time      = stamp;
		item.in_sms_sent  = sent;
		send(item);
	endtask

	// hold off until every awaited result has come back
	task automatic settle();
		req_valid <= 1'b0;
		do @(negedge clk); while (awaited != 0);
		@(posedge clk);
	endtask

	// result side: random stalls, one long hold-off to back the queue up
	initial begin
		int  wait_n;
		int  taken;
		bit  calm;
		taken = 0;
		calm  = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 9) == 0)
				calm = !calm;
			wait_n = calm ? 0 : $urandom_range(0, 17);
			if (taken == HOLD_OFF_AT)
				wait_n = HOLD_OFF_CYCLES;
			if (wait_n > 0) begin
				rsp_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
			taken++;
		end
	end

	// stimulus
	initial begin
		int   k;
		int   pick;
		req_t item;
		wait (arst_n);
		@(posedge clk);

		// empty queue: peek, commit beyond occupancy, unused code
		op(KIND_PEEK, 6'd63);
		op(KIND_COMMIT, 6'd63);
		op(KIND_SPARE, 6'd63);

		// length extremes, clamping and byte masking
		push_rec(4'd0, '1, 32'd0, 1'b0);
		push_rec(4'd7, '1, '1, 1'b1);
		push_rec(4'd8, '1, 32'h8000_0001, 1'b0);
		push_rec(4'd15, UIDB_W'({$urandom, $urandom}), $urandom, 1'b1);
		push_rec(4'd3, UIDB_W'({$urandom, $urandom}), $urandom, 1'b0);

		// peeks: count zero, count past occupancy, partial
		op(KIND_PEEK, 6'd0);
		op(KIND_PEEK, 6'd63);
		op(KIND_PEEK, 6'd2);
		op(KIND_SPARE, 6'd5);
		op(KIND_COMMIT, 6'd1);
		op(KIND_PEEK, 6'd1);
		op(KIND_COMMIT, 6'd63);
		op(KIND_PEEK, 6'd5);
		push_rec(4'd1, UIDB_W'({$urandom, $urandom}), $urandom, 1'b1);
		op(KIND_PEEK, 6'd1);

		// sender waits for the block to drain completely
		settle();

		// fill past capacity so the last pushes are refused
		for (k = 0; k < FILL_ITEMS; k++)
			op(KIND_PUSH, CNT_W'($urandom_range(0, 63)));

		// mixed traffic around a mostly full ring
		for (k = 0; k < MIXED_ITEMS; k++) begin
			pick = $urandom_range(0, 19);
			if (pick < 8) begin
				item = rand_req(KIND_PUSH, CNT_W'($urandom_range(0, 63)));
			end else if (pick < 14) begin
				item = rand_req(KIND_PEEK, ($urandom_range(0, 3) == 0)
					? CNT_W'($urandom_range(0, 63)) : CNT_W'($urandom_range(0, 8)));
			end else if (pick < 18) begin
				item = rand_req(KIND_COMMIT, ($urandom_range(0, 4) == 0)
					? CNT_W'($urandom_range(0, 63)) : CNT_W'($urandom_range(0, 4)));
			end else begin
				item = rand_req(KIND_SPARE, CNT_W'($urandom_range(0, 63)));
			end
			send(item);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d requests, %0d results, %0d pushes refused on a full ring",
			requests, results, refused);
		$display("run: %0d records peeked, highest occupancy %0d", peeked, peak_held);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
